### rtl/ubuf_pkg.sv
// Package for the buffered UART channel: ring depths, derived widths,
// command and result codes, and the control/status structs between the
// controller and the datapath. No dependencies.
package ubuf_pkg;

    localparam int RX_DEPTH    = 16;
    localparam int TX_DEPTH    = 16;
    localparam int MAX_RESULTS = 16;

    localparam int CMD_W  = 2;
    localparam int BYTE_W = 8;
    localparam int KIND_W = 2;
    localparam int LVL_W  = 5;
    localparam int EVT_W  = 8;

    localparam int RX_AW  = $clog2(RX_DEPTH);
    localparam int TX_AW  = $clog2(TX_DEPTH);
    localparam int RX_FW  = $clog2(RX_DEPTH + 1);
    localparam int TX_FW  = $clog2(TX_DEPTH + 1);
    localparam int LEFT_W = $clog2(MAX_RESULTS + 1);
    localparam int N_W    = (RX_FW > BYTE_W) ? RX_FW : BYTE_W;

    localparam logic [CMD_W-1:0] CMD_RX_BYTE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TX_DONE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_HOST_WR = 2'd2;
    localparam logic [CMD_W-1:0] CMD_HOST_RD = 2'd3;

    localparam logic [KIND_W-1:0] KIND_STATUS = 2'd0;
    localparam logic [KIND_W-1:0] KIND_HOST   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TX     = 2'd2;

    typedef struct packed {
        logic capture;
        logic exec;
        logic rd_issue;
        logic load_rd;
        logic load_tx;
    } t_ctrl_cmd;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             imm_result;
        logic             left_zero;
        logic             out_free;
    } t_ctrl_stat;

    function automatic logic [RX_AW-1:0] rx_next(input logic [RX_AW-1:0] p);
        return (p == RX_AW'(RX_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [TX_AW-1:0] tx_next(input logic [TX_AW-1:0] p);
        return (p == TX_AW'(TX_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

endpackage

### rtl/ubuf_in_if.sv
// Request channel into the buffered UART channel: valid/ready plus the
// command fields. Depends on ubuf_pkg for field widths.
interface ubuf_in_if;
    logic                        valid;
    logic                        ready;
    logic [ubuf_pkg::CMD_W-1:0]  command;
    logic [ubuf_pkg::BYTE_W-1:0] data;
    logic [ubuf_pkg::BYTE_W-1:0] max_count;

    modport source(output valid, command, data, max_count, input ready);
    modport sink(input valid, command, data, max_count, output ready);
endinterface

### rtl/ubuf_out_if.sv
// Result channel out of the buffered UART channel: valid/ready plus the
// result fields. Depends on ubuf_pkg for field widths.
interface ubuf_out_if;
    logic                        valid;
    logic                        ready;
    logic [ubuf_pkg::KIND_W-1:0] kind;
    logic [ubuf_pkg::BYTE_W-1:0] data_byte;
    logic                        last;
    logic                        accepted;
    logic [ubuf_pkg::LVL_W-1:0]  rx_level;
    logic [ubuf_pkg::LVL_W-1:0]  tx_level;
    logic [ubuf_pkg::EVT_W-1:0]  rx_events;
    logic [ubuf_pkg::EVT_W-1:0]  tx_events;

    modport source(output valid, kind, data_byte, last, accepted, rx_level, tx_level,
                   rx_events, tx_events, input ready);
    modport sink(input valid, kind, data_byte, last, accepted, rx_level, tx_level,
                 rx_events, tx_events, output ready);
endinterface

### rtl/ubuf_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module ubuf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/ubuf_ctrl.sv
// Sequencing controller for the buffered UART channel: takes one request
// at a time and steps the datapath through it. Depends on ubuf_pkg.
module ubuf_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  ubuf_pkg::t_ctrl_stat i_stat,
    output ubuf_pkg::t_ctrl_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_EXEC     = 3'd1;
    localparam logic [2:0] S_RD_ISSUE = 3'd2;
    localparam logic [2:0] S_RD_LOAD  = 3'd3;
    localparam logic [2:0] S_TX_LOAD  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                // Every request waits here until the output register can take a result.
                if (i_stat.out_free) begin
                    o_cmd.exec = 1'b1;
                    if (i_stat.imm_result) begin
                        n_state = S_IDLE;
                    end else if (i_stat.cmd == ubuf_pkg::CMD_HOST_RD) begin
                        n_state = S_RD_ISSUE;
                    end else begin
                        n_state = S_TX_LOAD;
                    end
                end
            end
            S_RD_ISSUE: begin
                o_cmd.rd_issue = 1'b1;
                n_state        = S_RD_LOAD;
            end
            S_RD_LOAD: begin
                if (i_stat.out_free) begin
                    o_cmd.load_rd = 1'b1;
                    n_state       = i_stat.left_zero ? S_IDLE : S_RD_ISSUE;
                end
            end
            S_TX_LOAD: begin
                if (i_stat.out_free) begin
                    o_cmd.load_tx = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_no_load_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_stat.out_free |-> !(o_cmd.exec || o_cmd.load_rd || o_cmd.load_tx))
        else $error("result loaded while output register still occupied");

    a_one_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.capture, o_cmd.exec, o_cmd.rd_issue, o_cmd.load_rd, o_cmd.load_tx}))
        else $error("more than one datapath action in a cycle");

    a_read_has_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.exec && !i_stat.imm_result && i_stat.cmd == ubuf_pkg::CMD_HOST_RD)
            |=> !i_stat.left_zero)
        else $error("deferred host read started with nothing to take");

endmodule

### rtl/ubuf_dp.sv
// Datapath of the buffered UART channel: both rings with their pointers and
// fill counts, event counters and the result register. Depends on ubuf_pkg
// and ubuf_ram.
module ubuf_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ubuf_pkg::t_ctrl_cmd         i_cmd,
    output ubuf_pkg::t_ctrl_stat        o_stat,
    input  logic [ubuf_pkg::CMD_W-1:0]  i_command,
    input  logic [ubuf_pkg::BYTE_W-1:0] i_data,
    input  logic [ubuf_pkg::BYTE_W-1:0] i_max_count,
    input  logic                        i_ready,
    output logic                        o_valid,
    output logic [ubuf_pkg::KIND_W-1:0] o_kind,
    output logic [ubuf_pkg::BYTE_W-1:0] o_data_byte,
    output logic                        o_last,
    output logic                        o_accepted,
    output logic [ubuf_pkg::LVL_W-1:0]  o_rx_level,
    output logic [ubuf_pkg::LVL_W-1:0]  o_tx_level,
    output logic [ubuf_pkg::EVT_W-1:0]  o_rx_events,
    output logic [ubuf_pkg::EVT_W-1:0]  o_tx_events
);

    // Captured request.
    logic [ubuf_pkg::CMD_W-1:0]  r_cmd_code, n_cmd_code;
    logic [ubuf_pkg::BYTE_W-1:0] r_data, n_data;
    logic [ubuf_pkg::BYTE_W-1:0] r_maxc, n_maxc;

    // Ring and counter state.
    logic [ubuf_pkg::RX_AW-1:0]  r_rx_head, n_rx_head, r_rx_tail, n_rx_tail;
    logic [ubuf_pkg::RX_FW-1:0]  r_rx_fill, n_rx_fill;
    logic [ubuf_pkg::TX_AW-1:0]  r_tx_head, n_tx_head, r_tx_tail, n_tx_tail;
    logic [ubuf_pkg::TX_FW-1:0]  r_tx_fill, n_tx_fill;
    logic                        r_tx_busy, n_tx_busy;
    logic [ubuf_pkg::EVT_W-1:0]  r_rx_evt, n_rx_evt, r_tx_evt, n_tx_evt;
    logic [ubuf_pkg::LEFT_W-1:0] r_left, n_left;

    // Result register.
    logic                        r_out_valid, n_out_valid;
    logic [ubuf_pkg::KIND_W-1:0] r_kind, n_kind;
    logic [ubuf_pkg::BYTE_W-1:0] r_byte, n_byte;
    logic                        r_last, n_last;
    logic                        r_acc, n_acc;
    logic [ubuf_pkg::LVL_W-1:0]  r_rx_lvl, n_rx_lvl, r_tx_lvl, n_tx_lvl;
    logic [ubuf_pkg::EVT_W-1:0]  r_rx_evt_o, n_rx_evt_o, r_tx_evt_o, n_tx_evt_o;

    logic                        rx_we, rx_re, tx_we, tx_re;
    logic [ubuf_pkg::BYTE_W-1:0] rx_rdata, tx_rdata;
    logic                        rx_full, tx_full, tx_empty, out_free, load;
    logic [ubuf_pkg::N_W-1:0]    maxc_w, fill_w, take_w;
    logic [ubuf_pkg::LEFT_W-1:0] take;
    logic [ubuf_pkg::KIND_W-1:0] ld_kind;
    logic [ubuf_pkg::BYTE_W-1:0] ld_byte;
    logic                        ld_last, ld_acc;

    ubuf_ram #(.WIDTH(ubuf_pkg::BYTE_W), .DEPTH(ubuf_pkg::RX_DEPTH)) u_rx_ram (
        .i_clk   (i_clk),
        .i_we    (rx_we),
        .i_waddr (r_rx_head),
        .i_wdata (r_data),
        .i_re    (rx_re),
        .i_raddr (r_rx_tail),
        .o_rdata (rx_rdata)
    );

    ubuf_ram #(.WIDTH(ubuf_pkg::BYTE_W), .DEPTH(ubuf_pkg::TX_DEPTH)) u_tx_ram (
        .i_clk   (i_clk),
        .i_we    (tx_we),
        .i_waddr (r_tx_head),
        .i_wdata (r_data),
        .i_re    (tx_re),
        .i_raddr (r_tx_tail),
        .o_rdata (tx_rdata)
    );

    assign rx_full  = (r_rx_fill == ubuf_pkg::RX_FW'(ubuf_pkg::RX_DEPTH));
    assign tx_full  = (r_tx_fill == ubuf_pkg::TX_FW'(ubuf_pkg::TX_DEPTH));
    assign tx_empty = (r_tx_fill == '0);
    assign out_free = !r_out_valid || i_ready;

    // Bytes a host read takes: the smallest of request, fill and result limit.
    always_comb begin
        maxc_w = ubuf_pkg::N_W'(r_maxc);
        fill_w = ubuf_pkg::N_W'(r_rx_fill);
        take_w = (maxc_w < fill_w) ? maxc_w : fill_w;
        if (take_w > ubuf_pkg::N_W'(ubuf_pkg::MAX_RESULTS)) begin
            take_w = ubuf_pkg::N_W'(ubuf_pkg::MAX_RESULTS);
        end
        take = ubuf_pkg::LEFT_W'(take_w);
    end

    always_comb begin
        o_stat.cmd        = r_cmd_code;
        o_stat.imm_result = !((r_cmd_code == ubuf_pkg::CMD_TX_DONE && !tx_empty) ||
                              (r_cmd_code == ubuf_pkg::CMD_HOST_RD && take != '0));
        o_stat.left_zero  = (r_left == '0);
        o_stat.out_free   = out_free;
    end

    always_comb begin
        n_cmd_code = r_cmd_code;
        n_data     = r_data;
        n_maxc     = r_maxc;
        n_rx_head  = r_rx_head;
        n_rx_tail  = r_rx_tail;
        n_rx_fill  = r_rx_fill;
        n_tx_head  = r_tx_head;
        n_tx_tail  = r_tx_tail;
        n_tx_fill  = r_tx_fill;
        n_tx_busy  = r_tx_busy;
        n_rx_evt   = r_rx_evt;
        n_tx_evt   = r_tx_evt;
        n_left     = r_left;
        rx_we      = 1'b0;
        rx_re      = 1'b0;
        tx_we      = 1'b0;
        tx_re      = 1'b0;
        load       = 1'b0;
        ld_kind    = ubuf_pkg::KIND_STATUS;
        ld_byte    = '0;
        ld_last    = 1'b1;
        ld_acc     = 1'b1;

        if (i_cmd.capture) begin
            n_cmd_code = i_command;
            n_data     = i_data;
            n_maxc     = i_max_count;
        end

        if (i_cmd.exec) begin
            unique case (r_cmd_code)
                ubuf_pkg::CMD_RX_BYTE: begin
                    n_rx_evt = r_rx_evt + 1'b1;
                    load     = 1'b1;
                    ld_acc   = !rx_full;
                    if (!rx_full) begin
                        rx_we     = 1'b1;
                        n_rx_head = ubuf_pkg::rx_next(r_rx_head);
                        n_rx_fill = r_rx_fill + ubuf_pkg::RX_FW'(1);
                    end
                end
                ubuf_pkg::CMD_TX_DONE: begin
                    n_tx_evt = r_tx_evt + 1'b1;
                    if (!tx_empty) begin
                        n_tx_busy = 1'b1;
                        tx_re     = 1'b1;
                        n_tx_tail = ubuf_pkg::tx_next(r_tx_tail);
                        n_tx_fill = r_tx_fill - ubuf_pkg::TX_FW'(1);
                    end else begin
                        n_tx_busy = 1'b0;
                        load      = 1'b1;
                    end
                end
                ubuf_pkg::CMD_HOST_WR: begin
                    load = 1'b1;
                    if (tx_full) begin
                        ld_acc = 1'b0;
                    end else begin
                        tx_we     = 1'b1;
                        n_tx_head = ubuf_pkg::tx_next(r_tx_head);
                        if (!r_tx_busy) begin
                            // An idle transmitter implies an empty ring, so the written
                            // byte is the one popped and is passed on directly.
                            n_tx_busy = 1'b1;
                            n_tx_tail = ubuf_pkg::tx_next(r_tx_tail);
                            ld_kind   = ubuf_pkg::KIND_TX;
                            ld_byte   = r_data;
                        end else begin
                            n_tx_fill = r_tx_fill + ubuf_pkg::TX_FW'(1);
                        end
                    end
                end
                ubuf_pkg::CMD_HOST_RD: begin
                    if (take == '0) begin
                        load = 1'b1;
                    end else begin
                        // The fill drops by the whole read up front so every result
                        // of this request reports the level after the step.
                        n_left    = take;
                        n_rx_fill = r_rx_fill - ubuf_pkg::RX_FW'(take);
                    end
                end
            endcase
        end

        if (i_cmd.rd_issue) begin
            rx_re     = 1'b1;
            n_rx_tail = ubuf_pkg::rx_next(r_rx_tail);
            n_left    = r_left - ubuf_pkg::LEFT_W'(1);
        end

        if (i_cmd.load_rd) begin
            load    = 1'b1;
            ld_kind = ubuf_pkg::KIND_HOST;
            ld_byte = rx_rdata;
            ld_last = (r_left == '0);
        end

        if (i_cmd.load_tx) begin
            load    = 1'b1;
            ld_kind = ubuf_pkg::KIND_TX;
            ld_byte = tx_rdata;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_kind      = r_kind;
        n_byte      = r_byte;
        n_last      = r_last;
        n_acc       = r_acc;
        n_rx_lvl    = r_rx_lvl;
        n_tx_lvl    = r_tx_lvl;
        n_rx_evt_o  = r_rx_evt_o;
        n_tx_evt_o  = r_tx_evt_o;
        if (load) begin
            n_out_valid = 1'b1;
            n_kind      = ld_kind;
            n_byte      = ld_byte;
            n_last      = ld_last;
            n_acc       = ld_acc;
            n_rx_lvl    = ubuf_pkg::LVL_W'(n_rx_fill);
            n_tx_lvl    = ubuf_pkg::LVL_W'(n_tx_fill);
            n_rx_evt_o  = n_rx_evt;
            n_tx_evt_o  = n_tx_evt;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_head   <= '0;
            r_rx_tail   <= '0;
            r_rx_fill   <= '0;
            r_tx_head   <= '0;
            r_tx_tail   <= '0;
            r_tx_fill   <= '0;
            r_tx_busy   <= 1'b0;
            r_rx_evt    <= '0;
            r_tx_evt    <= '0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_rx_head   <= n_rx_head;
            r_rx_tail   <= n_rx_tail;
            r_rx_fill   <= n_rx_fill;
            r_tx_head   <= n_tx_head;
            r_tx_tail   <= n_tx_tail;
            r_tx_fill   <= n_tx_fill;
            r_tx_busy   <= n_tx_busy;
            r_rx_evt    <= n_rx_evt;
            r_tx_evt    <= n_tx_evt;
            r_left      <= n_left;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd_code <= n_cmd_code;
        r_data     <= n_data;
        r_maxc     <= n_maxc;
        r_kind     <= n_kind;
        r_byte     <= n_byte;
        r_last     <= n_last;
        r_acc      <= n_acc;
        r_rx_lvl   <= n_rx_lvl;
        r_tx_lvl   <= n_tx_lvl;
        r_rx_evt_o <= n_rx_evt_o;
        r_tx_evt_o <= n_tx_evt_o;
    end

    assign o_valid     = r_out_valid;
    assign o_kind      = r_kind;
    assign o_data_byte = r_byte;
    assign o_last      = r_last;
    assign o_accepted  = r_acc;
    assign o_rx_level  = r_rx_lvl;
    assign o_tx_level  = r_tx_lvl;
    assign o_rx_events = r_rx_evt_o;
    assign o_tx_events = r_tx_evt_o;

    a_rx_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rx_fill <= ubuf_pkg::RX_FW'(ubuf_pkg::RX_DEPTH))
        else $error("receive fill count beyond ring depth");

    a_tx_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tx_fill <= ubuf_pkg::TX_FW'(ubuf_pkg::TX_DEPTH))
        else $error("transmit fill count beyond ring depth");

    a_idle_tx_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_tx_busy |-> (r_tx_fill == '0))
        else $error("bytes queued while the transmitter is idle");

endmodule

### rtl/uart_buffered_rx_tx_channel.sv
// Buffered UART channel: receive ring and transmit ring with host access.
// Request channel i_in carries command, data and max_count; result channel
// o_out carries one or more results per request, the final one flagged by
// last. Both use valid/ready and move a request or result when both are high.
// Commands: received byte (stored or dropped when full), transmitter done
// (hands out the next queued byte or idles the transmitter), host write
// (queued, passed straight to an idle transmitter, or refused when full) and
// host read (up to max_count held bytes, at most 16, oldest first, or one
// status result when nothing is taken).
// One request is worked on at a time. A single-result request has its result
// loaded in the execute step after acceptance; a transmitter done that pops a
// byte first reads the ring RAM and then loads the byte; a host read of n bytes
// alternates a ring read and a result load, the cost of the registered ring
// RAM read and the single result register per byte. Each load waits until the
// result register is free.
// The next request is accepted while the last result still waits in the
// result register. If the receiver stalls, work halts at the next result.
// Reset clears pointers, fill counts, event counters and the transmitter
// state; ring contents are not cleared and need no clearing pass.
// Depends on ubuf_pkg, ubuf_in_if, ubuf_out_if, ubuf_ctrl and ubuf_dp.
module uart_buffered_rx_tx_channel (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ubuf_in_if.sink    i_in,
    ubuf_out_if.source o_out
);

    ubuf_pkg::t_ctrl_cmd  ctrl_cmd;
    ubuf_pkg::t_ctrl_stat ctrl_stat;

    ubuf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_stat     (ctrl_stat),
        .o_cmd      (ctrl_cmd)
    );

    ubuf_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (ctrl_cmd),
        .o_stat      (ctrl_stat),
        .i_command   (i_in.command),
        .i_data      (i_in.data),
        .i_max_count (i_in.max_count),
        .i_ready     (o_out.ready),
        .o_valid     (o_out.valid),
        .o_kind      (o_out.kind),
        .o_data_byte (o_out.data_byte),
        .o_last      (o_out.last),
        .o_accepted  (o_out.accepted),
        .o_rx_level  (o_out.rx_level),
        .o_tx_level  (o_out.tx_level),
        .o_rx_events (o_out.rx_events),
        .o_tx_events (o_out.tx_events)
    );

endmodule

### tb/ubuf_checker.sv
// Scoreboard for the buffered UART channel: watches the request and result
// channels, keeps its own copy of both rings and predicts every result.
// Depends on ubuf_pkg, ubuf_in_if and ubuf_out_if.
module ubuf_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    ubuf_in_if   i_req,
    ubuf_out_if  i_res,
    output int   o_fail_count,
    output int   o_pending
);

    typedef struct packed {
        logic [ubuf_pkg::KIND_W-1:0] kind;
        logic [ubuf_pkg::BYTE_W-1:0] data_byte;
        logic                        last;
        logic                        accepted;
        logic [ubuf_pkg::LVL_W-1:0]  rx_level;
        logic [ubuf_pkg::LVL_W-1:0]  tx_level;
        logic [ubuf_pkg::EVT_W-1:0]  rx_events;
        logic [ubuf_pkg::EVT_W-1:0]  tx_events;
    } t_chan_result;

    t_chan_result due_results[$];

    logic [ubuf_pkg::BYTE_W-1:0] rx_ring [ubuf_pkg::RX_DEPTH];
    logic [ubuf_pkg::BYTE_W-1:0] tx_ring [ubuf_pkg::TX_DEPTH];
    int                          rx_wr, rx_rd, rx_held;
    int                          tx_wr, tx_rd, tx_held;
    logic                        tx_running;
    logic [ubuf_pkg::EVT_W-1:0]  rx_event_tally;
    logic [ubuf_pkg::EVT_W-1:0]  tx_event_tally;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic t_chan_result make_result(input logic [ubuf_pkg::KIND_W-1:0] kind,
                                                 input logic [ubuf_pkg::BYTE_W-1:0] value,
                                                 input logic acc);
        t_chan_result r;
        r           = '0;
        r.kind      = kind;
        r.data_byte = value;
        r.accepted  = acc;
        return r;
    endfunction

    function automatic logic [ubuf_pkg::BYTE_W-1:0] pop_tx_byte();
        logic [ubuf_pkg::BYTE_W-1:0] b;
        b       = tx_ring[tx_rd];
        tx_rd   = (tx_rd + 1) % ubuf_pkg::TX_DEPTH;
        tx_held = tx_held - 1;
        return b;
    endfunction

    task automatic predict_request(input logic [ubuf_pkg::CMD_W-1:0] cmd,
                                   input logic [ubuf_pkg::BYTE_W-1:0] value,
                                   input logic [ubuf_pkg::BYTE_W-1:0] limit);
        t_chan_result batch [ubuf_pkg::MAX_RESULTS];
        int           n_out;
        int           take;
        n_out = 0;
        case (cmd)
            ubuf_pkg::CMD_RX_BYTE: begin
                rx_event_tally = rx_event_tally + 1'b1;
                if (rx_held < ubuf_pkg::RX_DEPTH) begin
                    rx_ring[rx_wr] = value;
                    rx_wr          = (rx_wr + 1) % ubuf_pkg::RX_DEPTH;
                    rx_held        = rx_held + 1;
                    batch[n_out]   = make_result(ubuf_pkg::KIND_STATUS, '0, 1'b1);
                end else begin
                    batch[n_out]   = make_result(ubuf_pkg::KIND_STATUS, '0, 1'b0);
                end
                n_out = n_out + 1;
            end
            ubuf_pkg::CMD_TX_DONE: begin
                tx_event_tally = tx_event_tally + 1'b1;
                if (tx_held > 0) begin
                    tx_running   = 1'b1;
                    batch[n_out] = make_result(ubuf_pkg::KIND_TX, pop_tx_byte(), 1'b1);
                end else begin
                    tx_running   = 1'b0;
                    batch[n_out] = make_result(ubuf_pkg::KIND_STATUS, '0, 1'b1);
                end
                n_out = n_out + 1;
            end
            ubuf_pkg::CMD_HOST_WR: begin
                if (tx_held >= ubuf_pkg::TX_DEPTH) begin
                    batch[n_out] = make_result(ubuf_pkg::KIND_STATUS, '0, 1'b0);
                end else begin
                    tx_ring[tx_wr] = value;
                    tx_wr          = (tx_wr + 1) % ubuf_pkg::TX_DEPTH;
                    tx_held        = tx_held + 1;
                    // An idle transmitter takes the byte straight through the ring.
                    if (!tx_running) begin
                        tx_running   = 1'b1;
                        batch[n_out] = make_result(ubuf_pkg::KIND_TX, pop_tx_byte(), 1'b1);
                    end else begin
                        batch[n_out] = make_result(ubuf_pkg::KIND_STATUS, '0, 1'b1);
                    end
                end
                n_out = n_out + 1;
            end
            default: begin
                take = int'(limit);
                if (take > rx_held) take = rx_held;
                if (take > ubuf_pkg::MAX_RESULTS) take = ubuf_pkg::MAX_RESULTS;
                if (take == 0) begin
                    batch[n_out] = make_result(ubuf_pkg::KIND_STATUS, '0, 1'b1);
                    n_out        = n_out + 1;
                end else begin
                    for (int i = 0; i < take; i++) begin
                        batch[n_out] = make_result(ubuf_pkg::KIND_HOST, rx_ring[rx_rd], 1'b1);
                        n_out        = n_out + 1;
                        rx_rd        = (rx_rd + 1) % ubuf_pkg::RX_DEPTH;
                        rx_held      = rx_held - 1;
                    end
                end
            end
        endcase
        // Levels and counters are those after the whole request.
        for (int k = 0; k < n_out; k++) begin
            batch[k].last      = (k == n_out - 1);
            batch[k].rx_level  = ubuf_pkg::LVL_W'(rx_held);
            batch[k].tx_level  = ubuf_pkg::LVL_W'(tx_held);
            batch[k].rx_events = rx_event_tally;
            batch[k].tx_events = tx_event_tally;
            due_results.push_back(batch[k]);
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_chan_result want;
        if (!i_rst_n) begin
            due_results.delete();
            rx_wr          = 0;
            rx_rd          = 0;
            rx_held        = 0;
            tx_wr          = 0;
            tx_rd          = 0;
            tx_held        = 0;
            tx_running     = 1'b0;
            rx_event_tally = '0;
            tx_event_tally = '0;
        end else begin
            if (i_res.valid && i_res.ready) begin
                if (due_results.size() == 0) begin
                    $error("unexpected result: kind %0d, data_byte %0d",
                           i_res.kind, i_res.data_byte);
                    o_fail_count++;
                end else begin
                    want = due_results.pop_front();
                    check_field("kind", 8'(want.kind), 8'(i_res.kind));
                    check_field("data_byte", want.data_byte, i_res.data_byte);
                    check_field("last", 8'(want.last), 8'(i_res.last));
                    check_field("accepted", 8'(want.accepted), 8'(i_res.accepted));
                    check_field("rx_level", 8'(want.rx_level), 8'(i_res.rx_level));
                    check_field("tx_level", 8'(want.tx_level), 8'(i_res.tx_level));
                    check_field("rx_events", want.rx_events, i_res.rx_events);
                    check_field("tx_events", want.tx_events, i_res.tx_events);
                end
            end
            if (i_req.valid && i_req.ready) begin
                predict_request(i_req.command, i_req.data, i_req.max_count);
            end
        end
        o_pending = due_results.size();
    end

endmodule

### tb/uart_buffered_rx_tx_channel_tb.sv
// Top of the buffered UART channel testbench: clock, reset, request stimulus
// and result back-pressure; the checker does all prediction and comparison.
// Depends on ubuf_pkg, ubuf_in_if, ubuf_out_if, ubuf_checker and the block.
module uart_buffered_rx_tx_channel_tb;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    bit   calm = 1'b0;
    bit   gaps_on = 1'b1;
    int   random_items;

    ubuf_in_if  req_ch ();
    ubuf_out_if res_ch ();

    uart_buffered_rx_tx_channel uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch),
        .o_out   (res_ch)
    );

    ubuf_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_res        (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Result side: random stall bursts and stretches of steady readiness; always ready when calm.
    initial begin : result_sink
        int stall_left;
        int steady_left;
        stall_left  = 0;
        steady_left = 0;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (calm) begin
                res_ch.ready <= 1'b1;
            end else if (stall_left > 0) begin
                res_ch.ready <= 1'b0;
                stall_left--;
            end else if (steady_left > 0) begin
                res_ch.ready <= 1'b1;
                steady_left--;
            end else if ($urandom_range(0, 2) == 0) begin
                res_ch.ready <= 1'b0;
                stall_left = $urandom_range(1, 18) - 1;
            end else begin
                res_ch.ready <= 1'b1;
                steady_left = $urandom_range(1, 40);
            end
        end
    end

    // Called just after a rising edge; returns just after the edge that took it.
    task automatic send_request(input logic [ubuf_pkg::CMD_W-1:0] cmd,
                                input logic [ubuf_pkg::BYTE_W-1:0] value,
                                input logic [ubuf_pkg::BYTE_W-1:0] limit);
        req_ch.valid     <= 1'b1;
        req_ch.command   <= cmd;
        req_ch.data      <= value;
        req_ch.max_count <= limit;
        @(negedge i_clk);
        while (!req_ch.ready) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    function automatic logic [ubuf_pkg::CMD_W-1:0] CMD_CMD_NOISE();
        return ubuf_pkg::CMD_W'($urandom_range(0, 3));
    endfunction

    task automatic hold_off(input int cycles);
        req_ch.valid     <= 1'b0;
        req_ch.command   <= CMD_CMD_NOISE();
        req_ch.data      <= 8'($urandom);
        req_ch.max_count <= 8'($urandom);
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic maybe_gap();
        if (!calm && gaps_on && $urandom_range(0, 4) == 0) hold_off($urandom_range(1, 18));
    endtask

    task automatic drain_results();
        req_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    function automatic logic [ubuf_pkg::BYTE_W-1:0] pick_limit();
        if ($urandom_range(0, 2) == 0) return 8'($urandom_range(0, 255));
        return 8'($urandom_range(0, 20));
    endfunction

    task automatic send_one(input logic [ubuf_pkg::CMD_W-1:0] cmd,
                            input logic [ubuf_pkg::BYTE_W-1:0] value,
                            input logic [ubuf_pkg::BYTE_W-1:0] limit);
        maybe_gap();
        send_request(cmd, value, limit);
    endtask

    initial begin : stimulus
        int pick;
        int len;
        int group_no;
        i_rst_n          <= 1'b0;
        req_ch.valid     <= 1'b0;
        req_ch.command   <= ubuf_pkg::CMD_RX_BYTE;
        req_ch.data      <= '0;
        req_ch.max_count <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: idle transmitter, queued writes, empty rings, read limits.
        send_one(ubuf_pkg::CMD_HOST_RD, 8'h77, 8'd0);
        send_one(ubuf_pkg::CMD_TX_DONE, 8'h00, 8'hFF);
        send_one(ubuf_pkg::CMD_HOST_WR, 8'hFF, 8'h00);
        send_one(ubuf_pkg::CMD_HOST_WR, 8'h00, 8'h13);
        send_one(ubuf_pkg::CMD_HOST_WR, 8'h5A, 8'hFF);
        send_one(ubuf_pkg::CMD_TX_DONE, 8'hFF, 8'h00);
        send_one(ubuf_pkg::CMD_TX_DONE, 8'h81, 8'h42);
        send_one(ubuf_pkg::CMD_TX_DONE, 8'h00, 8'h00);
        send_one(ubuf_pkg::CMD_RX_BYTE, 8'h00, 8'hFF);
        send_one(ubuf_pkg::CMD_RX_BYTE, 8'hFF, 8'h00);
        send_one(ubuf_pkg::CMD_RX_BYTE, 8'hA5, 8'h3C);
        send_one(ubuf_pkg::CMD_HOST_RD, 8'hFF, 8'd0);
        send_one(ubuf_pkg::CMD_HOST_RD, 8'h00, 8'd2);
        send_one(ubuf_pkg::CMD_HOST_RD, 8'h12, 8'd255);
        send_one(ubuf_pkg::CMD_HOST_RD, 8'h34, 8'd1);
        send_one(ubuf_pkg::CMD_HOST_WR, 8'h3C, 8'h99);
        send_one(ubuf_pkg::CMD_TX_DONE, 8'hC3, 8'h01);
        drain_results();

        // Random: bursts of one command type (or of random commands), so that both rings fill and drain.
        random_items = 0;
        group_no     = 0;
        while (random_items < 112) begin
            calm    = (random_items >= 90);
            gaps_on = ($urandom_range(0, 3) != 0);
            pick    = $urandom_range(0, 9);
            len     = $urandom_range(1, 20);
            case (group_no)
                0: begin pick = 0; len = 18; end
                1: begin pick = 3; len = 1; end
                2: begin pick = 5; len = 18; end
                3: begin pick = 7; len = 18; end
                default: ;
            endcase
            if (pick == 3 || pick == 4) len = $urandom_range(1, 3);
            if (pick == 9) len = $urandom_range(1, 6);
            for (int i = 0; i < len; i++) begin
                case (pick) inside
                    [0:2]: send_one(ubuf_pkg::CMD_RX_BYTE, 8'($urandom), 8'($urandom));
                    [3:4]: begin
                        if (group_no == 1) begin
                            send_one(ubuf_pkg::CMD_HOST_RD, 8'($urandom), 8'd255);
                        end else begin
                            send_one(ubuf_pkg::CMD_HOST_RD, 8'($urandom), pick_limit());
                        end
                    end
                    [5:6]: send_one(ubuf_pkg::CMD_HOST_WR, 8'($urandom), 8'($urandom));
                    [7:8]: send_one(ubuf_pkg::CMD_TX_DONE, 8'($urandom), 8'($urandom));
                    default: send_one(CMD_CMD_NOISE(), 8'($urandom), pick_limit());
                endcase
            end
            random_items += len;
            group_no++;
            if (group_no == 8) drain_results();
        end

        drain_results();
        repeat (40) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

### files.f
rtl/ubuf_pkg.sv
rtl/ubuf_in_if.sv
rtl/ubuf_out_if.sv
rtl/ubuf_ram.sv
rtl/ubuf_ctrl.sv
rtl/ubuf_dp.sv
rtl/uart_buffered_rx_tx_channel.sv
tb/ubuf_checker.sv
tb/uart_buffered_rx_tx_channel_tb.sv
